/* sv/vptd_pkg.sv */
// Package for the virtual periodic tick divider: field widths, mode codes,
// command/status structs and the rate-to-exponent decode.
// No dependencies.
`default_nettype none

package vptd_pkg;

    // Field widths
    localparam int MODE_W    = 3;
    localparam int CHAN_W    = 2;
    localparam int PRESENT_W = 3;
    localparam int RATE_W    = 32;
    localparam int BYTES_W   = 8;
    localparam int ACC_W     = 3;
    localparam int PERIOD_W  = 16;
    localparam int COUNT_W   = 10;
    localparam int EXP_W     = 4;

    localparam int S_TDATA_W = 48;  // 45 payload bits, padded to bytes
    localparam int M_TDATA_W = 16;  // 11 payload bits, padded to bytes

    // Defaults and fixed constants
    localparam int DEF_NUM_CHANNELS = 3;
    localparam int DEF_BASE_RATE_HZ = 1024;
    localparam int MAX_RATE_EXP     = 10;

    localparam logic [BYTES_W-1:0]  REQUIRED_BYTES = 8'd4;
    localparam logic [ACC_W-1:0]    ACCEPTED_BYTES = 3'd4;
    localparam logic [PERIOD_W-1:0] ALARM_PERIOD_RESET = 16'd16384;
    localparam logic [EXP_W-1:0]    EXP_RESET = 4'd1;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_RATE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLR_PEND = 3'd4;

    // Per-channel command, qualified by the beat handshake
    typedef struct packed {
        logic             tick;
        logic             open;
        logic             close;
        logic             set_rate;
        logic             clr_pend;
        logic [EXP_W-1:0] rate_exp;
    } chan_cmd_t;

    typedef struct packed {
        logic pending;   // pending flag after this beat
        logic wake;      // flag set by this tick
    } chan_stat_t;

    // Returns 1..MAX_RATE_EXP for a power-of-two rate in range, else 0.
    function automatic logic [EXP_W-1:0] rate_exponent(input logic [RATE_W-1:0] rate);
        logic [EXP_W-1:0] e;
        e = '0;
        for (int k = 1; k <= MAX_RATE_EXP; k++) begin
            if (rate == (RATE_W'(1) << k)) begin
                e = EXP_W'(k);
            end
        end
        return e;
    endfunction

endpackage

`default_nettype wire

/* sv/vptd_chan.sv */
// One divider channel: enable, rate exponent, tick counter, pending flag.
// Depends on vptd_pkg.
`default_nettype none

module vptd_chan #(
    parameter int BASE_RATE_HZ = vptd_pkg::DEF_BASE_RATE_HZ
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire vptd_pkg::chan_cmd_t  cmd,
    output vptd_pkg::chan_stat_t      stat
);
    import vptd_pkg::*;

    localparam int CNT1_W = COUNT_W + 1;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [EXP_W-1:0]   exp_reg, exp_next;
    logic               en_reg, en_next;
    logic               pend_reg, pend_next;

    logic [CNT1_W-1:0]  period;
    logic [CNT1_W-1:0]  count_inc;
    logic               fire;

    // Period is the base rate shifted down by the exponent; zero fires every tick.
    assign period    = CNT1_W'(BASE_RATE_HZ) >> exp_reg;
    assign count_inc = {1'b0, count_reg} + CNT1_W'(1);
    assign fire      = cmd.tick && en_reg && (count_inc >= period);

    always_comb begin
        count_next = count_reg;
        exp_next   = exp_reg;
        en_next    = en_reg;
        pend_next  = pend_reg;
        if (cmd.tick && en_reg) begin
            if (fire) begin
                count_next = '0;
                pend_next  = 1'b1;
            end else begin
                count_next = count_inc[COUNT_W-1:0];
            end
        end
        if (cmd.open) begin
            count_next = '0;
            exp_next   = EXP_RESET;
            en_next    = 1'b1;
            pend_next  = 1'b0;
        end
        if (cmd.close) begin
            en_next = 1'b0;
        end
        if (cmd.set_rate) begin
            exp_next = cmd.rate_exp;
        end
        if (cmd.clr_pend) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            exp_reg   <= EXP_RESET;
            en_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            exp_reg   <= exp_next;
            en_reg    <= en_next;
            pend_reg  <= pend_next;
        end
    end

    assign stat.pending = pend_next;
    assign stat.wake    = fire;

endmodule

`default_nettype wire

/* sv/virtual_periodic_tick_divider_unit.sv */
// Virtual periodic tick divider: per-channel periodic flags from one base tick.
// A beat's result appears in the output register in the cycle after the beat.
// Throughput: one beat per cycle; the input is taken while a result waits
// whenever the output register is being drained in the same cycle.
// Reset (aresetn low, synchronous) closes all channels, clears counters and
// flags, sets every rate to 2 Hz and the alarm period to 16384 ticks.
`default_nettype none

module virtual_periodic_tick_divider_unit #(
    parameter int NUM_CHANNELS = vptd_pkg::DEF_NUM_CHANNELS,
    parameter int BASE_RATE_HZ = vptd_pkg::DEF_BASE_RATE_HZ
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_we,
    input  wire  [vptd_pkg::PERIOD_W-1:0]     cfg_wdata,     // alarm_period_ticks
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // channel[1:0], present_mask[4:2], rate_hz[36:5], byte_count[44:37], zero pad
    input  wire  [vptd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire  [vptd_pkg::MODE_W-1:0]       s_axis_tuser,  // mode[2:0]
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // status[0], bytes_accepted[3:1], wake_mask[6:4], pending_mask[9:7],
    // alarm_fire[10], zero pad
    output logic [vptd_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
    import vptd_pkg::*;

    localparam int ACTIVE_CH = (NUM_CHANNELS < PRESENT_W) ? NUM_CHANNELS : PRESENT_W;
    localparam int ALARM1_W  = PERIOD_W + 1;

    // Input fields
    logic [MODE_W-1:0]    mode;
    logic [CHAN_W-1:0]    channel;
    logic [PRESENT_W-1:0] present_mask;
    logic [RATE_W-1:0]    rate_hz;
    logic [BYTES_W-1:0]   byte_count;

    assign mode         = s_axis_tuser;
    assign channel      = s_axis_tdata[1:0];
    assign present_mask = s_axis_tdata[4:2];
    assign rate_hz      = s_axis_tdata[36:5];
    assign byte_count   = s_axis_tdata[44:37];

    logic                  accept;
    logic [PRESENT_W-1:0]  present_shift;
    logic                  chan_ok;
    logic [EXP_W-1:0]      new_exp;
    logic                  rate_ok;
    logic                  is_tick;

    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign present_shift = present_mask >> channel;
    assign chan_ok       = (32'(channel) < ACTIVE_CH) && present_shift[0];
    assign new_exp       = rate_exponent(rate_hz);
    assign rate_ok       = (byte_count == REQUIRED_BYTES) && (new_exp != '0);
    assign is_tick       = (mode == MODE_TICK);

    // Channels
    chan_cmd_t  cmd  [ACTIVE_CH];
    chan_stat_t stat [ACTIVE_CH];
    logic [ACTIVE_CH-1:0] pend_vec;
    logic [ACTIVE_CH-1:0] wake_vec;

    for (genvar i = 0; i < ACTIVE_CH; i++) begin : g_chan
        logic sel;
        assign sel = accept && chan_ok && (channel == CHAN_W'(i));

        assign cmd[i].tick     = accept && is_tick && present_mask[i];
        assign cmd[i].open     = sel && (mode == MODE_OPEN);
        assign cmd[i].close    = sel && (mode == MODE_CLOSE);
        assign cmd[i].set_rate = sel && (mode == MODE_SET_RATE) && rate_ok;
        assign cmd[i].clr_pend = sel && (mode == MODE_CLR_PEND);
        assign cmd[i].rate_exp = new_exp;

        vptd_chan #(
            .BASE_RATE_HZ (BASE_RATE_HZ)
        ) u_chan (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd[i]),
            .stat    (stat[i])
        );

        assign pend_vec[i] = stat[i].pending;
        assign wake_vec[i] = stat[i].wake;
    end

    // Alarm counter and period register
    logic [PERIOD_W-1:0] alarm_period_reg;
    logic [PERIOD_W-1:0] alarm_count_reg, alarm_count_next;
    logic [ALARM1_W-1:0] alarm_inc;
    logic                alarm_hit;
    logic                alarm_fire;

    assign alarm_inc  = {1'b0, alarm_count_reg} + ALARM1_W'(1);
    assign alarm_hit  = alarm_inc >= {1'b0, alarm_period_reg};
    assign alarm_fire = accept && is_tick && alarm_hit && chan_ok;

    always_comb begin
        alarm_count_next = alarm_count_reg;
        if (accept && is_tick) begin
            alarm_count_next = alarm_hit ? '0 : alarm_inc[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_period_reg <= ALARM_PERIOD_RESET;
            alarm_count_reg  <= '0;
        end else begin
            if (cfg_we) begin
                alarm_period_reg <= cfg_wdata;
            end
            alarm_count_reg <= alarm_count_next;
        end
    end

    // Result
    logic                 status;
    logic [ACC_W-1:0]     bytes_accepted;
    logic [PRESENT_W-1:0] wake_mask;
    logic [PRESENT_W-1:0] pending_mask;

    always_comb begin
        unique case (mode)
            MODE_TICK:                          status = 1'b0;
            MODE_OPEN, MODE_CLOSE, MODE_CLR_PEND: status = !chan_ok;
            MODE_SET_RATE:                      status = !(chan_ok && rate_ok);
            default:                            status = 1'b1;
        endcase
    end

    assign bytes_accepted = (mode == MODE_SET_RATE && chan_ok && rate_ok) ? ACCEPTED_BYTES
                                                                          : '0;
    assign wake_mask      = PRESENT_W'(wake_vec);
    assign pending_mask   = PRESENT_W'(pend_vec);

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            m_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {5'b0, alarm_fire, pending_mask, wake_mask, bytes_accepted, status};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Checks
    a_wake_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((m_axis_tdata[6:4] & ~m_axis_tdata[9:7]) == '0))
        else $error("wake bit without pending bit");

    a_accept_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[3:1] != '0) |-> !m_axis_tdata[0])
        else $error("bytes accepted on an error result");

    a_non_tick_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_tick) |=> (m_axis_tdata[6:4] == '0 && !m_axis_tdata[10]))
        else $error("wake or alarm on a non-tick beat");

    a_alarm_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_tick && !alarm_hit) |=> (alarm_count_reg == $past(alarm_count_reg) + 1'b1))
        else $error("alarm counter did not advance");

endmodule

`default_nettype wire
